FILE: hw/rtl/blr_pkg.sv
// types, codes and constants shared by the backlight level remap writer
`timescale 1ns / 1ps

package blr_pkg;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_ON   = 2'd1,
		OP_OFF  = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_USER_FLOOR    = 3'd0,
		CFG_USER_MID      = 3'd1,
		CFG_USER_TOP      = 3'd2,
		CFG_PANEL_FLOOR   = 3'd3,
		CFG_PANEL_MID     = 3'd4,
		CFG_PANEL_TOP     = 3'd5,
		CFG_DEFAULT_LEVEL = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIN,
		ST_CMP,
		ST_EMIT_DIM,
		ST_EMIT_MODE,
		ST_EMIT_DUTY,
		ST_EMIT_READ
	} state_t;

	typedef enum logic [1:0] {
		SEL_DIM,
		SEL_MODE,
		SEL_DUTY,
		SEL_READ
	} out_sel_t;

	localparam logic [7:0]  USER_FLOOR_RST    = 8'd30;
	localparam logic [7:0]  USER_MID_RST      = 8'd143;
	localparam logic [7:0]  USER_TOP_RST      = 8'd255;
	localparam logic [7:0]  PANEL_FLOOR_RST   = 8'd11;
	localparam logic [7:0]  PANEL_MID_RST     = 8'd103;
	localparam logic [7:0]  PANEL_TOP_RST     = 8'd218;
	localparam logic [7:0]  DEFAULT_LEVEL_RST = 8'd100;
	localparam logic [7:0]  APPLIED_LEVEL_RST = 8'd100;

	localparam logic [15:0] ADDR_DIM  = 16'h5300;
	localparam logic [7:0]  DATA_DIM  = 8'h2C;
	localparam logic [15:0] ADDR_MODE = 16'h5500;
	localparam logic [15:0] ADDR_DUTY = 16'h5100;

	localparam logic        KIND_WRITE = 1'b0;
	localparam logic        KIND_REPLY = 1'b1;

	localparam int          DIV_BITS = 16;

	typedef struct packed {
		op_t        operation;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] reg_address;
		logic [7:0]  reg_data;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic     load;
		logic     mul;
		logic     div_start;
		logic     div_step;
		logic     finish;
		logic     emit;
		out_sel_t sel;
		logic     commit;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic gate_on;
		logic dim_use;
		logic duty_differs;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hw/rtl/blr_ctrl.sv
// controller state machine sequencing map, divide and register writes
`timescale 1ns / 1ps

module blr_ctrl
	import blr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (status.op)
					OP_SET:  state_d = status.gate_on ? ST_MUL : ST_IDLE;
					OP_ON:   state_d = ST_MUL;
					OP_OFF:  state_d = ST_IDLE;
					OP_READ: state_d = ST_EMIT_READ;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_MUL:      state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_last) state_d = ST_FIN;
			end
			ST_FIN:      state_d = ST_CMP;
			ST_CMP: begin
				priority if (!status.duty_differs) state_d = ST_IDLE;
				else if (status.dim_use) state_d = ST_EMIT_DIM;
				else state_d = ST_EMIT_MODE;
			end
			ST_EMIT_DIM: begin
				if (status.out_free) state_d = ST_EMIT_MODE;
			end
			ST_EMIT_MODE: begin
				if (status.out_free) state_d = ST_EMIT_DUTY;
			end
			ST_EMIT_DUTY: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			ST_EMIT_READ: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_DIM;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL:      cmd.mul = 1'b1;
			ST_DIV_INIT: cmd.div_start = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_FIN:      cmd.finish = 1'b1;
			ST_EMIT_DIM: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_DIM;
			end
			ST_EMIT_MODE: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_MODE;
			end
			ST_EMIT_DUTY: begin
				cmd.emit   = status.out_free;
				cmd.sel    = SEL_DUTY;
				cmd.commit = status.out_free;
			end
			ST_EMIT_READ: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_READ;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/blr_dp.sv
// datapath: settings, backlight state, segment multiply, serial divider, output register
`timescale 1ns / 1ps

module blr_dp
	import blr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  logic       out_ready,
	output logic       out_valid,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status
);

	// settings
	logic [7:0] user_floor_q, user_mid_q, user_top_q;
	logic [7:0] panel_floor_q, panel_mid_q, panel_top_q, default_level_q;

	// backlight state
	logic       gate_on_q, dim_pending_q;
	logic [7:0] last_duty_q, applied_level_q, requested_level_q;

	// current item
	op_t        op_q;
	logic [7:0] lvl_q;
	logic       dim_use_q;

	// map and divide
	logic signed [17:0] prod_q;
	logic signed [8:0]  den_q;
	logic [7:0]         base_q;
	logic               below_q;
	logic [15:0]        quo_q;
	logic [7:0]         rem_q;
	logic [7:0]         dvs_q;
	logic               neg_q;
	logic               den_zero_q;
	logic [3:0]         cnt_q;
	logic [7:0]         duty_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic               above_c;
	logic signed [8:0]  a_c, b_c, den_c;
	logic signed [17:0] prod_neg_c;
	logic signed [8:0]  den_neg_c;
	logic [8:0]         trial_c;
	logic               take_c;
	logic signed [17:0] qs_c, r_c;
	logic [7:0]         clamp_c;
	out_item_t          emit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_floor_q    <= USER_FLOOR_RST;
			user_mid_q      <= USER_MID_RST;
			user_top_q      <= USER_TOP_RST;
			panel_floor_q   <= PANEL_FLOOR_RST;
			panel_mid_q     <= PANEL_MID_RST;
			panel_top_q     <= PANEL_TOP_RST;
			default_level_q <= DEFAULT_LEVEL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_USER_FLOOR:    user_floor_q    <= cfg_data;
				CFG_USER_MID:      user_mid_q      <= cfg_data;
				CFG_USER_TOP:      user_top_q      <= cfg_data;
				CFG_PANEL_FLOOR:   panel_floor_q   <= cfg_data;
				CFG_PANEL_MID:     panel_mid_q     <= cfg_data;
				CFG_PANEL_TOP:     panel_top_q     <= cfg_data;
				CFG_DEFAULT_LEVEL: default_level_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_on_q         <= 1'b0;
			dim_pending_q     <= 1'b1;
			last_duty_q       <= '0;
			applied_level_q   <= APPLIED_LEVEL_RST;
			requested_level_q <= '0;
			op_q              <= OP_SET;
			dim_use_q         <= 1'b0;
		end else if (cmd.load) begin
			op_q <= in_item.operation;
			unique case (in_item.operation)
				OP_SET: begin
					requested_level_q <= in_item.level;
					dim_use_q         <= dim_pending_q;
				end
				OP_ON: begin
					gate_on_q     <= 1'b1;
					dim_use_q     <= dim_pending_q;
					dim_pending_q <= 1'b1;
				end
				OP_OFF: begin
					gate_on_q   <= 1'b0;
					last_duty_q <= '0;
				end
				OP_READ: begin
				end
				default: begin
				end
			endcase
		end else if (cmd.commit) begin
			last_duty_q     <= duty_q;
			applied_level_q <= lvl_q;
			if (op_q == OP_SET && dim_use_q) dim_pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (in_item.operation == OP_SET) begin
				lvl_q <= in_item.level;
			end else begin
				lvl_q <= (requested_level_q == '0) ? default_level_q : requested_level_q;
			end
		end
	end

	// segment select and product
	always_comb begin
		above_c = lvl_q > user_mid_q;
		if (above_c) begin
			a_c   = $signed({1'b0, panel_top_q}) - $signed({1'b0, panel_mid_q});
			b_c   = $signed({1'b0, lvl_q}) - $signed({1'b0, user_mid_q});
			den_c = $signed({1'b0, user_top_q}) - $signed({1'b0, user_mid_q});
		end else begin
			a_c   = $signed({1'b0, panel_mid_q}) - $signed({1'b0, panel_floor_q});
			b_c   = $signed({1'b0, lvl_q}) - $signed({1'b0, user_floor_q});
			den_c = $signed({1'b0, user_mid_q}) - $signed({1'b0, user_floor_q});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q  <= 18'(a_c) * 18'(b_c);
			den_q   <= den_c;
			base_q  <= above_c ? panel_mid_q : panel_floor_q;
			below_q <= lvl_q < user_floor_q;
		end
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	assign prod_neg_c = -prod_q;
	assign den_neg_c  = -den_q;
	assign trial_c    = {rem_q, quo_q[DIV_BITS-1]};
	assign take_c     = trial_c >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q      <= prod_q[17] ? prod_neg_c[15:0] : prod_q[15:0];
			dvs_q      <= den_q[8] ? den_neg_c[7:0] : den_q[7:0];
			rem_q      <= '0;
			neg_q      <= prod_q[17] ^ den_q[8];
			den_zero_q <= den_q == '0;
		end else if (cmd.div_step) begin
			rem_q <= take_c ? 8'(trial_c - {1'b0, dvs_q}) : trial_c[7:0];
			quo_q <= {quo_q[DIV_BITS-2:0], take_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// signed quotient, base and clamp
	always_comb begin
		qs_c = $signed({2'b00, quo_q});
		if (den_zero_q) qs_c = '0;
		else if (neg_q) qs_c = -qs_c;
		r_c = qs_c + $signed({10'd0, base_q});
		priority if (r_c[17]) clamp_c = 8'd0;
		else if (r_c > 18'sd255) clamp_c = 8'd255;
		else clamp_c = r_c[7:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) duty_q <= below_q ? panel_floor_q : clamp_c;
	end

	// result register
	always_comb begin
		emit_c = '0;
		unique case (cmd.sel)
			SEL_DIM: begin
				emit_c.kind        = KIND_WRITE;
				emit_c.reg_address = ADDR_DIM;
				emit_c.reg_data    = DATA_DIM;
			end
			SEL_MODE: begin
				emit_c.kind        = KIND_WRITE;
				emit_c.reg_address = ADDR_MODE;
			end
			SEL_DUTY: begin
				emit_c.kind        = KIND_WRITE;
				emit_c.reg_address = ADDR_DUTY;
				emit_c.reg_data    = duty_q;
				emit_c.last_of_run = 1'b1;
			end
			SEL_READ: begin
				emit_c.kind        = KIND_REPLY;
				emit_c.reg_data    = applied_level_q;
				emit_c.last_of_run = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_q <= emit_c;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		status.op           = op_q;
		status.gate_on      = gate_on_q;
		status.dim_use      = dim_use_q;
		status.duty_differs = duty_q != last_duty_q;
		status.div_last     = cnt_q == 4'(DIV_BITS - 1);
		status.out_free     = !out_valid_q || out_ready;
	end

endmodule

FILE: hw/rtl/backlight_level_remap_writer_top.sv
// top level: maps a brightness level to panel PWM register writes
// a level change runs through load, decode, multiply, a 16-step serial divider,
// clamp, compare and up to three writes, each of which waits for a free output
// a read reply is emitted after decode once the output is free; off gives no result
// one item at a time, taken only while idle; configuration is always ready
// asynchronous active-low reset restores register defaults, gate off, dim write pending
`timescale 1ns / 1ps

module backlight_level_remap_writer_top
	import blr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	blr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	blr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: bench/backlight_level_remap_writer_top_tb.sv
// self-checking bench for the backlight level remap writer: predicted panel writes vs dut output
`timescale 1ns / 1ps

module backlight_level_remap_writer_top_tb;
	import blr_pkg::*;

	localparam int SETTLE_CYCLES = 60;
	localparam int PHASE_ITEMS = 13;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_CHOKED
	} rx_mode_t;

	typedef struct {
		logic       is_cfg;
		in_item_t   item;
		cfg_idx_t   idx;
		logic [7:0] data;
	} bench_step_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	bench_step_t queued_steps[$];
	out_item_t   writes_due[$];

	// predictor copy of registers and state
	logic [7:0] cfg_regs [0:6];
	logic       gate_open;
	logic [7:0] prev_duty;
	logic       dim_owed;
	logic [7:0] shown_level;
	logic [7:0] asked_level;

	logic [7:0] plan_regs [0:6];

	int       fault_count;
	int       quiet_cycles;
	int       gap_left;
	int       burst_left;
	int       mode_left;
	rx_mode_t rx_mode;

	backlight_level_remap_writer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] remap_duty(input logic [7:0] lvl);
		int b;
		int uf;
		int um;
		int ut;
		int pf;
		int pm;
		int pt;
		int num;
		int den;
		int base;
		int r;
		b = lvl;
		uf = cfg_regs[CFG_USER_FLOOR];
		um = cfg_regs[CFG_USER_MID];
		ut = cfg_regs[CFG_USER_TOP];
		pf = cfg_regs[CFG_PANEL_FLOOR];
		pm = cfg_regs[CFG_PANEL_MID];
		pt = cfg_regs[CFG_PANEL_TOP];
		if (b < uf) begin
			return cfg_regs[CFG_PANEL_FLOOR];
		end
		if (b > um) begin
			num = (pt - pm) * (b - um);
			den = ut - um;
			base = pm;
		end else begin
			num = (pm - pf) * (b - uf);
			den = um - uf;
			base = pf;
		end
		r = (den == 0) ? 0 : num / den;
		r = r + base;
		if (r < 0) begin
			r = 0;
		end
		if (r > 255) begin
			r = 255;
		end
		return r[7:0];
	endfunction

	task automatic apply_duty(input logic [7:0] lvl);
		logic [7:0] duty;
		if (gate_open) begin
			duty = remap_duty(lvl);
			if (duty != prev_duty) begin
				if (dim_owed) begin
					writes_due.push_back(out_item_t'{KIND_WRITE, ADDR_DIM, DATA_DIM, 1'b0});
					dim_owed = 1'b0;
				end
				writes_due.push_back(out_item_t'{KIND_WRITE, ADDR_MODE, 8'h00, 1'b0});
				writes_due.push_back(out_item_t'{KIND_WRITE, ADDR_DUTY, duty, 1'b1});
				prev_duty = duty;
				shown_level = lvl;
			end
		end
	endtask

	task automatic predict_panel_writes(input in_item_t it);
		logic [7:0] lvl;
		case (it.operation)
			OP_SET: begin
				asked_level = it.level;
				apply_duty(it.level);
			end
			OP_ON: begin
				gate_open = 1'b1;
				lvl = (asked_level == 8'd0) ? cfg_regs[CFG_DEFAULT_LEVEL] : asked_level;
				apply_duty(lvl);
				dim_owed = 1'b1;
			end
			OP_OFF: begin
				gate_open = 1'b0;
				prev_duty = 8'd0;
			end
			OP_READ: begin
				writes_due.push_back(out_item_t'{KIND_REPLY, 16'h0000, shown_level, 1'b1});
			end
		endcase
	endtask

	task automatic add_item(input op_t op, input logic [7:0] lvl);
		bench_step_t s;
		s.is_cfg = 1'b0;
		s.item.operation = op;
		s.item.level = lvl;
		s.idx = CFG_USER_FLOOR;
		s.data = 8'd0;
		queued_steps.push_back(s);
	endtask

	task automatic add_setting(input logic [7:0] uf, um, ut, pf, pm, pt, dl);
		bench_step_t s;
		plan_regs = '{uf, um, ut, pf, pm, pt, dl};
		for (int i = 0; i < 7; i++) begin
			s.is_cfg = 1'b1;
			s.item.operation = OP_READ;
			s.item.level = 8'd0;
			s.idx = cfg_idx_t'(i);
			s.data = plan_regs[i];
			queued_steps.push_back(s);
		end
	endtask

	function automatic logic [7:0] pick_level();
		int r;
		logic [7:0] knee;
		r = $urandom_range(0, 99);
		knee = plan_regs[$urandom_range(0, 2)];
		if (r < 25) begin
			case ($urandom_range(0, 3))
				0: return 8'd0;
				1: return 8'd1;
				2: return 8'd254;
				default: return 8'd255;
			endcase
		end
		if (r < 50) begin
			return knee + 8'($urandom_range(0, 2)) - 8'd1;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// sender: bursts with random gaps, registers only once the block has gone quiet
	always @(posedge clk) begin : driver
		bench_step_t head;
		logic in_next;
		logic cfg_next;
		logic took_item;
		if (arst_n) begin
			took_item = in_valid && in_ready;
			in_next = in_valid && !in_ready;
			cfg_next = cfg_valid && !cfg_ready;
			if (took_item) begin
				predict_panel_writes(in_item);
			end
			if (cfg_valid && cfg_ready) begin
				cfg_regs[cfg_index] = cfg_data;
			end
			if (!in_next && !cfg_next && queued_steps.size() != 0) begin
				head = queued_steps[0];
				if (head.is_cfg) begin
					if (!took_item && writes_due.size() == 0 &&
					    quiet_cycles >= SETTLE_CYCLES) begin
						void'(queued_steps.pop_front());
						cfg_next = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.data;
					end
				end else if (gap_left != 0) begin
					gap_left--;
				end else begin
					void'(queued_steps.pop_front());
					in_next = 1'b1;
					in_item <= head.item;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end
			end
			in_valid <= in_next;
			cfg_valid <= cfg_next;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || out_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < SETTLE_CYCLES) begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: checks each transfer against the oldest predicted write
	always @(posedge clk) begin : monitor
		out_item_t want;
		logic ready_next;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (writes_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("unexpected result: kind %0d addr %h data %h last %0d",
							out_item.kind, out_item.reg_address, out_item.reg_data,
							out_item.last_of_run);
					end
				end else begin
					want = writes_due.pop_front();
					if (out_item.kind !== want.kind ||
					    out_item.reg_address !== want.reg_address ||
					    out_item.reg_data !== want.reg_data ||
					    out_item.last_of_run !== want.last_of_run) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("mismatch: expected kind %0d addr %h data %h last %0d",
								want.kind, want.reg_address, want.reg_data,
								want.last_of_run);
							$display("          actual   kind %0d addr %h data %h last %0d",
								out_item.kind, out_item.reg_address, out_item.reg_data,
								out_item.last_of_run);
						end
					end
				end
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_OPEN: ready_next = 1'b1;
				RX_COIN: ready_next = ($urandom_range(0, 1) == 1);
				RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
				RX_CHOKED: ready_next = ($urandom_range(0, 15) == 0);
			endcase
			out_ready <= ready_next;
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int r;
		op_t op;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 3'd0;
		cfg_data = 8'd0;
		fault_count = 0;
		quiet_cycles = 0;
		gap_left = 0;
		burst_left = 0;
		mode_left = 0;
		rx_mode = RX_OPEN;
		cfg_regs = '{USER_FLOOR_RST, USER_MID_RST, USER_TOP_RST, PANEL_FLOOR_RST,
			PANEL_MID_RST, PANEL_TOP_RST, DEFAULT_LEVEL_RST};
		plan_regs = cfg_regs;
		gate_open = 1'b0;
		prev_duty = 8'd0;
		dim_owed = 1'b1;
		shown_level = APPLIED_LEVEL_RST;
		asked_level = 8'd0;

		// directed: gate off, dim lead-in, floor and mid knees, default level on switch-on
		add_item(OP_READ, 8'd0);
		add_item(OP_SET, 8'd200);
		add_item(OP_READ, 8'd255);
		add_item(OP_ON, 8'd0);
		add_item(OP_SET, 8'd200);
		add_item(OP_SET, 8'd0);
		add_item(OP_SET, 8'd29);
		add_item(OP_SET, 8'd30);
		add_item(OP_SET, 8'd143);
		add_item(OP_SET, 8'd144);
		add_item(OP_SET, 8'd255);
		add_item(OP_READ, 8'd0);
		add_item(OP_OFF, 8'd0);
		add_item(OP_SET, 8'd0);
		add_item(OP_ON, 8'd0);
		add_item(OP_ON, 8'd0);
		add_item(OP_READ, 8'd0);
		add_item(OP_OFF, 8'd0);
		add_item(OP_ON, 8'd0);
		// zero segment spans
		add_setting(8'd100, 8'd100, 8'd100, 8'd20, 8'd40, 8'd218, 8'd100);
		add_item(OP_SET, 8'd99);
		add_item(OP_SET, 8'd100);
		add_item(OP_SET, 8'd101);
		// misordered points, negative quotient clamped to zero
		add_setting(8'd200, 8'd50, 8'd0, 8'd255, 8'd0, 8'd255, 8'd100);
		add_item(OP_SET, 8'd255);
		// steep top segment clamped to full scale
		add_setting(8'd0, 8'd0, 8'd1, 8'd0, 8'd200, 8'd255, 8'd100);
		add_item(OP_SET, 8'd255);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: add_setting(8'd30, 8'd143, 8'd255, 8'd11, 8'd103, 8'd218, 8'd100);
				1: add_setting(8'd30, 8'd143, 8'd255, 8'd9, 8'd135, 8'd255, 8'd0);
				2: add_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				3: add_setting(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				4: add_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: begin
					r = $urandom_range(0, 80);
					plan_regs[0] = 8'(r);
					plan_regs[1] = 8'($urandom_range(r + 1, 180));
					plan_regs[2] = 8'($urandom_range(plan_regs[1] + 1, 255));
					add_setting(plan_regs[0], plan_regs[1], plan_regs[2],
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			endcase
			add_item(OP_ON, 8'($urandom_range(0, 255)));
			for (int k = 1; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					op = OP_SET;
				end else if (r < 70) begin
					op = OP_READ;
				end else if (r < 85) begin
					op = OP_ON;
				end else begin
					op = OP_OFF;
				end
				add_item(op, (op == OP_SET) ? pick_level() : 8'($urandom_range(0, 255)));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (queued_steps.size() != 0 || in_valid || cfg_valid) begin
			@(posedge clk);
		end
		while (writes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
